// ----- rtl/core/dpwv_pkg.sv -----
// Shared types, constants and fixed-point helpers for the dual-wheel PID
// velocity controller. No dependencies; every other file imports this package.
package dpwv_pkg;

	localparam int DATA_W    = 32;
	localparam int FRAC_BITS = 16;
	localparam int RANGE_W   = 16;
	localparam int PROD_W    = 2 * DATA_W;
	localparam int Q_W       = PROD_W - FRAC_BITS;
	localparam int CFG_IDX_W = 3;
	localparam int QDEPTH    = 4;
	localparam int PTR_W     = $clog2(QDEPTH);
	localparam int CNT_W     = $clog2(QDEPTH + 1);

	localparam logic [RANGE_W-1:0]       LANE_THRESHOLD = RANGE_W'(10);
	localparam logic signed [PROD_W-1:0] BOOST          = 64'sd2 <<< FRAC_BITS;
	localparam logic signed [PROD_W-1:0] ROUND_HALF     = 64'sd1 <<< (FRAC_BITS - 1);
	localparam logic signed [PROD_W-1:0] DATA_MAX       = (64'sd1 <<< (DATA_W - 1)) - 64'sd1;
	localparam logic signed [PROD_W-1:0] DATA_MIN       = -DATA_MAX - 64'sd1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN_PROP,
		REG_GAIN_INT,
		REG_DERIV_COEF,
		REG_DERIV_DECAY,
		REG_INTEG_MAX,
		REG_INTEG_MIN,
		REG_DRIVE_MAX,
		REG_DRIVE_MIN
	} cfg_reg_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] gain_prop;
		logic signed [DATA_W-1:0] gain_int_half_period;
		logic signed [DATA_W-1:0] deriv_coef;
		logic signed [DATA_W-1:0] deriv_decay;
		logic signed [DATA_W-1:0] integ_max;
		logic signed [DATA_W-1:0] integ_min;
		logic signed [DATA_W-1:0] drive_max;
		logic signed [DATA_W-1:0] drive_min;
	} pid_cfg_t;

	typedef struct packed {
		logic signed [DATA_W-1:0]  meas_vel_left;
		logic signed [DATA_W-1:0]  meas_vel_right;
		logic signed [DATA_W-1:0]  target_vel_left;
		logic signed [DATA_W-1:0]  target_vel_right;
		logic        [RANGE_W-1:0] range_left;
		logic        [RANGE_W-1:0] range_right;
	} wheel_in_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] drive_left;
		logic signed [DATA_W-1:0] drive_right;
	} wheel_out_t;

	// one valid bit per pipeline stage, shared by both lanes
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} stage_vld_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] prop;
		logic signed [DATA_W-1:0] integ;
		logic signed [DATA_W-1:0] deriv;
	} lane_res_t;

	function automatic logic signed [PROD_W-1:0] ext_d(input logic signed [DATA_W-1:0] a);
		ext_d = {{(PROD_W - DATA_W){a[DATA_W-1]}}, a};
	endfunction

	function automatic logic signed [PROD_W-1:0] ext_q(input logic signed [Q_W-1:0] a);
		ext_q = {{(PROD_W - Q_W){a[Q_W-1]}}, a};
	endfunction

	function automatic logic signed [DATA_W-1:0] sat_d(input logic signed [PROD_W-1:0] v);
		if (v > DATA_MAX) begin
			sat_d = DATA_MAX[DATA_W-1:0];
		end else if (v < DATA_MIN) begin
			sat_d = DATA_MIN[DATA_W-1:0];
		end else begin
			sat_d = v[DATA_W-1:0];
		end
	endfunction

	// drop fraction bits of an exact product, half rounds toward plus infinity
	function automatic logic signed [Q_W-1:0] qround(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W-1:0] r;
		r = p + ROUND_HALF;
		qround = r[PROD_W-1:FRAC_BITS];
	endfunction

endpackage

// ----- rtl/core/dual_pid_wheel_velocity.sv -----
// Two-wheel PID velocity controller.
// Input channel (in_valid/in_ready/in_data): one request per control tick with
// both wheels' measured and target speeds and the two side range readings.
// Output channel (out_valid/out_ready/out_data): one result per request with
// both saturated drive commands, in request order.
// Configuration: cfg_wr_en writes cfg_data into register cfg_index at once;
// write only while no request is in flight.
// A request moves through stages s1 to s5 into the result queue, with later
// requests following in the lanes. in_ready is held low right after each accept
// for the derivative filter loop (multiply by previous derivative, then update).
// A four-entry result queue absorbs receiver stalls; in_ready drops once four
// requests are accepted but not yet taken, and the lanes never stall.
// Reset: all gains and limits, integrators, derivative and history state clear
// to zero; the queue empties.
// Lanes: one per wheel, running side by side; a merging stage sums and clamps.
module dual_pid_wheel_velocity (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  dpwv_pkg::wheel_in_t                   in_data,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output dpwv_pkg::wheel_out_t                  out_data,
	input  logic                                  cfg_wr_en,
	input  logic [dpwv_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [dpwv_pkg::DATA_W-1:0]           cfg_data
);
	import dpwv_pkg::*;

	pid_cfg_t          cfg_q;
	stage_vld_t        vld_q;
	logic [CNT_W-1:0]  credit_q;
	logic              acc_q;
	logic              in_acc, out_acc;
	logic              boost_left, boost_right;
	lane_res_t         res_left, res_right;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;
	// hold off the request right after an accept: derivative loop spacing
	assign in_ready = !acc_q && (credit_q < CNT_W'(QDEPTH));

	// lane keeping: right side has priority
	always_comb begin
		boost_right = (in_data.range_right < LANE_THRESHOLD);
		boost_left  = !boost_right && (in_data.range_left < LANE_THRESHOLD);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_GAIN_PROP:   cfg_q.gain_prop            <= cfg_data;
				REG_GAIN_INT:    cfg_q.gain_int_half_period <= cfg_data;
				REG_DERIV_COEF:  cfg_q.deriv_coef           <= cfg_data;
				REG_DERIV_DECAY: cfg_q.deriv_decay          <= cfg_data;
				REG_INTEG_MAX:   cfg_q.integ_max            <= cfg_data;
				REG_INTEG_MIN:   cfg_q.integ_min            <= cfg_data;
				REG_DRIVE_MAX:   cfg_q.drive_max            <= cfg_data;
				REG_DRIVE_MIN:   cfg_q.drive_min            <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			acc_q    <= 1'b0;
			credit_q <= '0;
		end else begin
			vld_q.s1 <= in_acc;
			vld_q.s2 <= vld_q.s1;
			vld_q.s3 <= vld_q.s2;
			vld_q.s4 <= vld_q.s3;
			vld_q.s5 <= vld_q.s4;
			acc_q    <= in_acc;
			credit_q <= credit_q + CNT_W'(in_acc) - CNT_W'(out_acc);
		end
	end

	dpwv_lane u_lane_left (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.vld    (vld_q),
		.load   (in_acc),
		.boost  (boost_left),
		.target (in_data.target_vel_left),
		.meas   (in_data.meas_vel_left),
		.result (res_left)
	);

	dpwv_lane u_lane_right (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.vld    (vld_q),
		.load   (in_acc),
		.boost  (boost_right),
		.target (in_data.target_vel_right),
		.meas   (in_data.meas_vel_right),
		.result (res_right)
	);

	dpwv_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_vld   (vld_q.s5),
		.left      (res_left),
		.right     (res_right),
		.drive_max (cfg_q.drive_max),
		.drive_min (cfg_q.drive_min),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

`ifndef SYNTHESIS
	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		credit_q <= CNT_W'(QDEPTH))
		else $error("in-flight request count exceeds queue depth");

	a_accept_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_acc)
		else $error("requests accepted on consecutive cycles");

	a_deriv_hazard: assert property (@(posedge clk) disable iff (!arst_n)
		!(vld_q.s3 && vld_q.s4))
		else $error("derivative read overlaps pending update");

	a_out_has_credit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (credit_q != '0))
		else $error("result presented with no request in flight");
`endif

endmodule

// ----- rtl/core/dpwv_lane.sv -----
// One wheel's PID datapath: error, proportional, clamped trapezoidal integrator
// and band-limited derivative on the measurement. Depends on dpwv_pkg.
module dpwv_lane (
	input  logic                             clk,
	input  logic                             arst_n,
	input  dpwv_pkg::pid_cfg_t               cfg,
	input  dpwv_pkg::stage_vld_t             vld,
	input  logic                             load,
	input  logic                             boost,
	input  logic signed [dpwv_pkg::DATA_W-1:0] target,
	input  logic signed [dpwv_pkg::DATA_W-1:0] meas,
	output dpwv_pkg::lane_res_t              result
);
	import dpwv_pkg::*;

	logic signed [DATA_W-1:0] tgt_s1, meas_s1;
	logic signed [DATA_W-1:0] err_s2, dm_s2;
	logic signed [DATA_W-1:0] esum_s3;
	logic signed [PROD_W-1:0] prod_p_s3, prod_d_s3;
	logic signed [PROD_W-1:0] prod_i_s4, prod_r_s4;
	logic signed [DATA_W-1:0] prop_s4, prop_s5;
	logic signed [Q_W-1:0]    t1_s4;

	logic signed [DATA_W-1:0] last_meas_q, last_err_q, integ_q, deriv_q;

	logic signed [DATA_W-1:0] err, dm, esum, qi, ig_sum, ig, deriv_nxt;

	always_comb begin
		err       = sat_d(ext_d(tgt_s1) - ext_d(meas_s1));
		dm        = sat_d(ext_d(meas_s1) - ext_d(last_meas_q));
		esum      = sat_d(ext_d(err_s2) + ext_d(last_err_q));
		qi        = sat_d(ext_q(qround(prod_i_s4)));
		ig_sum    = sat_d(ext_d(integ_q) + ext_d(qi));
		// upper limit wins when the limits cross
		if (ig_sum > cfg.integ_max) begin
			ig = cfg.integ_max;
		end else if (ig_sum < cfg.integ_min) begin
			ig = cfg.integ_min;
		end else begin
			ig = ig_sum;
		end
		deriv_nxt = sat_d(-(ext_q(t1_s4) + ext_q(qround(prod_r_s4))));
	end

	// request payload with lane-keeping boost folded into the setpoint
	always_ff @(posedge clk) begin
		if (load) begin
			tgt_s1  <= boost ? sat_d(ext_d(target) + BOOST) : target;
			meas_s1 <= meas;
		end
	end

	always_ff @(posedge clk) begin
		err_s2    <= err;
		dm_s2     <= dm;
		esum_s3   <= esum;
		prod_p_s3 <= err_s2 * cfg.gain_prop;
		prod_d_s3 <= dm_s2 * cfg.deriv_coef;
		prod_i_s4 <= esum_s3 * cfg.gain_int_half_period;
		prod_r_s4 <= deriv_q * cfg.deriv_decay;
		prop_s4   <= sat_d(ext_q(qround(prod_p_s3)));
		t1_s4     <= qround(prod_d_s3);
		prop_s5   <= prop_s4;
	end

	// controller state, each read and written in a single stage, except deriv_q: read in s3, written in s4
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_meas_q <= '0;
			last_err_q  <= '0;
			integ_q     <= '0;
			deriv_q     <= '0;
		end else begin
			if (vld.s1) begin
				last_meas_q <= meas_s1;
			end
			if (vld.s2) begin
				last_err_q <= err_s2;
			end
			if (vld.s4) begin
				integ_q <= ig;
				deriv_q <= deriv_nxt;
			end
		end
	end

	assign result.prop  = prop_s5;
	assign result.integ = integ_q;
	assign result.deriv = deriv_q;

endmodule

// ----- rtl/core/dpwv_merge.sv -----
// Merging stage: sums the three terms of each lane, saturates to the drive
// limits and queues the result for the output channel. Depends on dpwv_pkg.
module dpwv_merge (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              res_vld,
	input  dpwv_pkg::lane_res_t               left,
	input  dpwv_pkg::lane_res_t               right,
	input  logic signed [dpwv_pkg::DATA_W-1:0] drive_max,
	input  logic signed [dpwv_pkg::DATA_W-1:0] drive_min,
	output logic                              out_valid,
	input  logic                              out_ready,
	output dpwv_pkg::wheel_out_t              out_data
);
	import dpwv_pkg::*;

	wheel_out_t        queue_q [QDEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  fill_q;
	wheel_out_t        merged;
	logic              pop;

	function automatic logic signed [DATA_W-1:0] drive_sat(
		input lane_res_t r,
		input logic signed [DATA_W-1:0] hi,
		input logic signed [DATA_W-1:0] lo
	);
		logic signed [PROD_W-1:0] sum;
		sum = ext_d(r.prop) + ext_d(r.integ) + ext_d(r.deriv);
		if (sum > ext_d(hi)) begin
			drive_sat = hi;
		end else if (sum < ext_d(lo)) begin
			drive_sat = lo;
		end else begin
			drive_sat = sum[DATA_W-1:0];
		end
	endfunction

	always_comb begin
		merged.drive_left  = drive_sat(left, drive_max, drive_min);
		merged.drive_right = drive_sat(right, drive_max, drive_min);
	end

	assign out_valid = (fill_q != '0);
	assign out_data  = queue_q[rd_ptr_q];
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (res_vld) begin
			queue_q[wr_ptr_q] <= merged;
		end
	end

	// upstream credit check keeps the queue from overflowing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (res_vld) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			fill_q <= fill_q + CNT_W'(res_vld) - CNT_W'(pop);
		end
	end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for dual_pid_wheel_velocity: a cycle-free PID predictor
// checks each drive pair; tasks drive requests and registers, a sink drives results.
// Depends on dpwv_pkg and the dual_pid_wheel_velocity RTL only.

import dpwv_pkg::*;

class drive_checker;
	pid_cfg_t   regs;
	longint     integ[2];
	longint     last_err[2];
	longint     deriv[2];
	longint     last_meas[2];
	wheel_out_t pending_drives[$];
	int         errors;
	int         compared;
	int         lane_boosts;

	function new();
		regs = '0;
		foreach (integ[i]) begin
			integ[i]     = 0;
			last_err[i]  = 0;
			deriv[i]     = 0;
			last_meas[i] = 0;
		end
		errors      = 0;
		compared    = 0;
		lane_boosts = 0;
	endfunction

	function void set_reg(cfg_reg_t idx, logic [DATA_W-1:0] value);
		case (idx)
			REG_GAIN_PROP:   regs.gain_prop = value;
			REG_GAIN_INT:    regs.gain_int_half_period = value;
			REG_DERIV_COEF:  regs.deriv_coef = value;
			REG_DERIV_DECAY: regs.deriv_decay = value;
			REG_INTEG_MAX:   regs.integ_max = value;
			REG_INTEG_MIN:   regs.integ_min = value;
			REG_DRIVE_MAX:   regs.drive_max = value;
			REG_DRIVE_MIN:   regs.drive_min = value;
			default: ;
		endcase
	endfunction

	function longint clip(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// exact product, then drop the fraction with half rounding up
	function longint qmul(longint a, longint b);
		longint p;
		p = a * b + (64'sd1 <<< (FRAC_BITS - 1));
		return p >>> FRAC_BITS;
	endfunction

	function longint wheel_step(int side, longint target, longint meas);
		longint err, prop, esum, acc, dmeas, t1, t2, drive;
		err  = clip(target - meas);
		prop = clip(qmul(regs.gain_prop, err));
		esum = clip(err + last_err[side]);
		acc  = clip(integ[side] + clip(qmul(regs.gain_int_half_period, esum)));
		// upper clamp wins even when the limits are crossed
		if (acc > regs.integ_max) acc = regs.integ_max;
		else if (acc < regs.integ_min) acc = regs.integ_min;
		dmeas = clip(meas - last_meas[side]);
		t1 = qmul(regs.deriv_coef, dmeas);
		t2 = qmul(regs.deriv_decay, deriv[side]);
		deriv[side] = clip(-(t1 + t2));
		drive = prop + acc + deriv[side];
		if (drive > regs.drive_max) drive = regs.drive_max;
		else if (drive < regs.drive_min) drive = regs.drive_min;
		integ[side]     = acc;
		last_err[side]  = err;
		last_meas[side] = meas;
		return drive;
	endfunction

	function void note_request(wheel_in_t req);
		longint     tl, tr, dl, dr;
		wheel_out_t want;
		tl = req.target_vel_left;
		tr = req.target_vel_right;
		// right side has priority for the lane boost
		if (req.range_right < LANE_THRESHOLD) begin
			tr = clip(tr + BOOST);
			lane_boosts++;
		end else if (req.range_left < LANE_THRESHOLD) begin
			tl = clip(tl + BOOST);
			lane_boosts++;
		end
		dl = wheel_step(0, tl, req.meas_vel_left);
		dr = wheel_step(1, tr, req.meas_vel_right);
		want.drive_left  = dl[DATA_W-1:0];
		want.drive_right = dr[DATA_W-1:0];
		pending_drives.push_back(want);
	endfunction

	task report_mismatch(string msg);
		errors++;
		if (errors <= 40) $display("[%0t] MISMATCH: %s", $realtime, msg);
	endtask

	task check_drive(wheel_out_t got);
		wheel_out_t want;
		if (pending_drives.size() == 0) begin
			report_mismatch($sformatf("result %h with no request pending", got));
			return;
		end
		want = pending_drives.pop_front();
		compared++;
		if (got.drive_left !== want.drive_left)
			report_mismatch($sformatf("drive_left got %h want %h (result %0d)",
				got.drive_left, want.drive_left, compared));
		if (got.drive_right !== want.drive_right)
			report_mismatch($sformatf("drive_right got %h want %h (result %0d)",
				got.drive_right, want.drive_right, compared));
	endtask
endclass

module tb_top;

	localparam logic [DATA_W-1:0]  S_MAX     = 32'h7FFF_FFFF;
	localparam logic [DATA_W-1:0]  S_MIN     = 32'h8000_0000;
	localparam logic [DATA_W-1:0]  ONE       = 32'h0001_0000;
	localparam logic [RANGE_W-1:0] RANGE_FAR = 16'd1000;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	wheel_in_t            in_data;
	logic                 out_valid;
	logic                 out_ready;
	wheel_out_t           out_data;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DATA_W-1:0]    cfg_data;

	drive_checker board = new();
	bit           req_taken;
	bit           gaps_on = 1'b1;
	bit           sink_hold_req;
	int           requests_sent;
	int           settings_loaded;

	dual_pid_wheel_velocity DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// sample both handshakes at the rising edge; drivers read req_taken at the falling edge
	always @(posedge clk) begin
		req_taken = in_valid && in_ready;
		if (req_taken) board.note_request(in_data);
		if (out_valid && out_ready) board.check_drive(out_data);
	end

	// result sink: random stalls, plus one long hold when asked
	initial begin : drive_sink
		int stall;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (sink_hold_req) begin
				out_ready <= 1'b0;
				repeat (80) @(negedge clk);
				sink_hold_req = 1'b0;
				out_ready <= 1'b1;
			end else if (gaps_on && $urandom_range(0, 5) == 0) begin
				stall = $urandom_range(1, 15);
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic send_request(input wheel_in_t req);
		int gap;
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 15);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= req;
		do @(negedge clk); while (!req_taken);
		requests_sent++;
	endtask

	task automatic wait_drained();
		while (board.pending_drives.size() != 0) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [DATA_W-1:0] value);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		board.set_reg(idx, value);
	endtask

	task automatic load_settings(input pid_cfg_t s);
		in_valid <= 1'b0;
		wait_drained();
		write_reg(REG_GAIN_PROP, s.gain_prop);
		write_reg(REG_GAIN_INT, s.gain_int_half_period);
		write_reg(REG_DERIV_COEF, s.deriv_coef);
		write_reg(REG_DERIV_DECAY, s.deriv_decay);
		write_reg(REG_INTEG_MAX, s.integ_max);
		write_reg(REG_INTEG_MIN, s.integ_min);
		write_reg(REG_DRIVE_MAX, s.drive_max);
		write_reg(REG_DRIVE_MIN, s.drive_min);
		cfg_wr_en <= 1'b0;
		settings_loaded++;
	endtask

	function automatic wheel_in_t mk(input logic [DATA_W-1:0] ml, mr, tl, tr,
			input logic [RANGE_W-1:0] rl, rr);
		wheel_in_t r;
		r.meas_vel_left    = ml;
		r.meas_vel_right   = mr;
		r.target_vel_left  = tl;
		r.target_vel_right = tr;
		r.range_left       = rl;
		r.range_right      = rr;
		return r;
	endfunction

	function automatic logic [DATA_W-1:0] rand_speed();
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: return $urandom_range(0, 1) ? S_MAX : S_MIN;
			default: return $urandom_range(0, 40 << FRAC_BITS) - (20 << FRAC_BITS);
		endcase
	endfunction

	function automatic logic [RANGE_W-1:0] rand_range();
		if ($urandom_range(0, 2) == 0)
			return RANGE_W'($urandom_range(0, 2 * LANE_THRESHOLD));
		return RANGE_W'($urandom);
	endfunction

	// measurement mostly tracks the setpoint so the integrator stays in play
	function automatic wheel_in_t rand_request();
		wheel_in_t r;
		r.target_vel_left  = rand_speed();
		r.target_vel_right = rand_speed();
		r.meas_vel_left  = ($urandom_range(0, 2) != 0) ?
			r.target_vel_left + $urandom_range(0, 2 << FRAC_BITS) - ONE : rand_speed();
		r.meas_vel_right = ($urandom_range(0, 2) != 0) ?
			r.target_vel_right + $urandom_range(0, 2 << FRAC_BITS) - ONE : rand_speed();
		r.range_left  = rand_range();
		r.range_right = rand_range();
		return r;
	endfunction

	function automatic pid_cfg_t rand_settings(input bit wild);
		pid_cfg_t          s;
		logic [DATA_W-1:0] t;
		if (wild) begin
			s = {$urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom, $urandom};
			return s;
		end
		s.gain_prop = $urandom_range(0, 3 << FRAC_BITS);
		if ($urandom_range(0, 3) == 0) s.gain_prop = -s.gain_prop;
		s.gain_int_half_period = $urandom_range(0, 1 << (FRAC_BITS - 2));
		s.deriv_coef  = $urandom_range(0, 2 << FRAC_BITS);
		s.deriv_decay = $urandom_range(0, 1 << FRAC_BITS);
		s.integ_max   = $urandom_range(1 << FRAC_BITS, 400 << FRAC_BITS);
		s.integ_min   = -$urandom_range(1 << FRAC_BITS, 400 << FRAC_BITS);
		s.drive_max   = $urandom_range(1 << FRAC_BITS, 800 << FRAC_BITS);
		s.drive_min   = -$urandom_range(1 << FRAC_BITS, 800 << FRAC_BITS);
		if ($urandom_range(0, 3) == 0) begin
			t           = s.integ_min;
			s.integ_min = s.integ_max;
			s.integ_max = t;
		end
		if ($urandom_range(0, 3) == 0) begin
			t           = s.drive_min;
			s.drive_min = s.drive_max;
			s.drive_max = t;
		end
		return s;
	endfunction

	initial begin
		#2_000_000;
		$display("TIMEOUT: run did not complete, %0d results still pending",
			board.pending_drives.size());
		$display("Mismatches found");
		$finish;
	end

	initial begin : stimulus
		pid_cfg_t s;
		in_valid      = 1'b0;
		in_data       = '0;
		cfg_wr_en     = 1'b0;
		cfg_index     = REG_GAIN_PROP;
		cfg_data      = '0;
		sink_hold_req = 1'b0;
		arst_n        = 1'b0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// moderate gains: kp 2.0, ki*T/2 0.25, coef 0.5, decay 0.75, limits 50 and 100
		s.gain_prop = 32'h0002_0000;
		s.gain_int_half_period = 32'h0000_4000;
		s.deriv_coef  = 32'h0000_8000;
		s.deriv_decay = 32'h0000_C000;
		s.integ_max   = 32'd50 << FRAC_BITS;
		s.integ_min   = -(32'd50 << FRAC_BITS);
		s.drive_max   = 32'd100 << FRAC_BITS;
		s.drive_min   = -(32'd100 << FRAC_BITS);
		load_settings(s);
		send_request(mk('0, '0, '0, '0, RANGE_FAR, RANGE_FAR));
		send_request(mk('0, '0, ONE, ONE, RANGE_FAR, RANGE_FAR));
		send_request(mk('0, '0, ONE, ONE, RANGE_FAR, LANE_THRESHOLD - RANGE_W'(1)));
		send_request(mk('0, '0, ONE, ONE, LANE_THRESHOLD, LANE_THRESHOLD));
		send_request(mk('0, '0, ONE, ONE, LANE_THRESHOLD - RANGE_W'(1), LANE_THRESHOLD));
		send_request(mk('0, '0, ONE, ONE, '0, '0));
		send_request(mk('0, '0, ONE, ONE, 16'hFFFF, 16'hFFFF));
		send_request(mk(S_MIN, S_MIN, S_MAX, S_MAX, RANGE_FAR, '0));
		repeat (3) send_request(mk(S_MIN, S_MIN, S_MAX, S_MAX, RANGE_FAR, RANGE_FAR));
		repeat (3) send_request(mk(S_MAX, S_MAX, S_MIN, S_MIN, '0, RANGE_FAR));

		// extreme gains with crossed clamps
		s = {S_MAX, S_MIN, S_MAX, S_MIN, S_MIN, S_MAX, S_MIN, S_MAX};
		load_settings(s);
		send_request(mk(S_MAX, S_MIN, S_MIN, S_MAX, '0, 16'hFFFF));
		send_request(mk(S_MIN, S_MAX, S_MAX, S_MIN, 16'hFFFF, '0));
		send_request(mk('0, '0, '0, '0, RANGE_FAR, RANGE_FAR));
		send_request(mk(ONE, -ONE, -ONE, ONE, LANE_THRESHOLD - RANGE_W'(1), RANGE_FAR));
		send_request(mk(S_MAX, S_MAX, S_MAX, S_MAX, RANGE_FAR, RANGE_FAR));

		// extreme gains with the widest limits
		s = {S_MIN, S_MAX, S_MIN, S_MAX, S_MAX, S_MIN, S_MAX, S_MIN};
		load_settings(s);
		send_request(mk(S_MAX, S_MIN, S_MIN, S_MAX, RANGE_FAR, RANGE_FAR));
		send_request(mk(S_MIN, S_MAX, S_MAX, S_MIN, RANGE_FAR, RANGE_FAR));
		send_request(mk(ONE, ONE, -ONE, -ONE, '0, '0));
		send_request(mk('0, '0, '0, '0, RANGE_FAR, RANGE_FAR));
		send_request(mk(-ONE, ONE, ONE, -ONE, LANE_THRESHOLD - RANGE_W'(1), 16'hFFFF));

		for (int phase = 0; phase < 6; phase++) begin
			load_settings(rand_settings(phase == 1 || phase == 4));
			if (phase == 5) gaps_on = 1'b0;
			// long receiver hold so the result queue fills and in_ready drops
			if (phase == 1) sink_hold_req = 1'b1;
			for (int n = 0; n < 72; n++) begin
				if (phase == 2 && n == 36) begin
					in_valid <= 1'b0;
					wait_drained();
				end
				send_request(rand_request());
			end
		end
		in_valid <= 1'b0;

		wait_drained();
		repeat (20) @(negedge clk);
		if (board.pending_drives.size() != 0)
			board.report_mismatch($sformatf("%0d results never arrived",
				board.pending_drives.size()));
		$display("Run covered %0d requests under %0d register settings (%0d lane boosts),",
			requests_sent, settings_loaded, board.lane_boosts);
		$display("with %0d drive pairs compared and %0d field errors.",
			board.compared, board.errors);
		if (board.errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
